/* sv/afc_pkg.sv */
// shared types and constants for the box against frustum cull test
// no dependencies
package afc_pkg;

	localparam int COORD_WIDTH_DEF    = 16;
	localparam int COEF_FRAC_BITS_DEF = 16;
	localparam int COEF_W             = 32;
	localparam int CFG_W              = 2 * COEF_W;
	localparam int NUM_CFG            = 8;
	localparam int CFG_IDX_W          = $clog2(NUM_CFG);
	localparam int NUM_CORNERS        = 8;
	localparam int NUM_ROWS           = 4;
	localparam int OC_W               = 6;

	// outcode bit positions
	localparam int OC_RIGHT  = 0;
	localparam int OC_LEFT   = 1;
	localparam int OC_TOP    = 2;
	localparam int OC_BOTTOM = 3;
	localparam int OC_FAR    = 4;
	localparam int OC_NEAR   = 5;

	// corner select: bit 0 x, bit 1 y, bit 2 z; set means take the maximum
	localparam logic [2:0] CORNER_SEL [NUM_CORNERS] = '{
		3'b000, 3'b001, 3'b011, 3'b010,
		3'b100, 3'b101, 3'b111, 3'b110
	};

	typedef enum logic [1:0] {
		VERDICT_REJECT  = 2'd0,
		VERDICT_PARTIAL = 2'd1,
		VERDICT_INSIDE  = 2'd2
	} verdict_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} adv_t;

endpackage

/* sv/afc_row_eval.sv */
// one row of the clip matrix evaluated at all eight box corners, three stages
// depends on afc_pkg
module afc_row_eval #(
	parameter int COORD_WIDTH = afc_pkg::COORD_WIDTH_DEF
) (
	input  logic                                    clk,
	input  afc_pkg::adv_t                           adv,
	input  logic signed [afc_pkg::COEF_W-1:0]       coef_x,
	input  logic signed [afc_pkg::COEF_W-1:0]       coef_y,
	input  logic signed [afc_pkg::COEF_W-1:0]       coef_z,
	input  logic signed [afc_pkg::COEF_W-1:0]       coef_t,
	input  logic signed [COORD_WIDTH-1:0]           lo_x,
	input  logic signed [COORD_WIDTH-1:0]           lo_y,
	input  logic signed [COORD_WIDTH-1:0]           lo_z,
	input  logic signed [COORD_WIDTH-1:0]           hi_x,
	input  logic signed [COORD_WIDTH-1:0]           hi_y,
	input  logic signed [COORD_WIDTH-1:0]           hi_z,
	output logic signed [COORD_WIDTH+afc_pkg::COEF_W+1:0] corner_s3 [afc_pkg::NUM_CORNERS]
);

	localparam int PW = COORD_WIDTH + afc_pkg::COEF_W;

	logic signed [PW-1:0] prod_x_s1 [2];
	logic signed [PW-1:0] prod_y_s1 [2];
	logic signed [PW-1:0] prod_z_s1 [2];
	logic signed [afc_pkg::COEF_W-1:0] coef_t_s1;
	logic signed [PW:0]   sum_tx_s2 [2];
	logic signed [PW:0]   sum_yz_s2 [4];

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			prod_x_s1[0] <= PW'(coef_x) * PW'(lo_x);
			prod_x_s1[1] <= PW'(coef_x) * PW'(hi_x);
			prod_y_s1[0] <= PW'(coef_y) * PW'(lo_y);
			prod_y_s1[1] <= PW'(coef_y) * PW'(hi_y);
			prod_z_s1[0] <= PW'(coef_z) * PW'(lo_z);
			prod_z_s1[1] <= PW'(coef_z) * PW'(hi_z);
			coef_t_s1    <= coef_t;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			for (int i = 0; i < 2; i++) begin
				sum_tx_s2[i] <= (PW+1)'(coef_t_s1) + (PW+1)'(prod_x_s1[i]);
			end
			for (int j = 0; j < 2; j++) begin
				for (int k = 0; k < 2; k++) begin
					sum_yz_s2[j*2+k] <= (PW+1)'(prod_y_s1[j]) + (PW+1)'(prod_z_s1[k]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			for (int c = 0; c < afc_pkg::NUM_CORNERS; c++) begin
				corner_s3[c] <= (PW+2)'(sum_tx_s2[afc_pkg::CORNER_SEL[c][0]])
					+ (PW+2)'(sum_yz_s2[{afc_pkg::CORNER_SEL[c][1],
						afc_pkg::CORNER_SEL[c][2]}]);
			end
		end
	end

endmodule

/* sv/aabb_frustum_cull_test.sv */
// throughput: one box word per cycle while box_stall is low; multipliers in
// stage 1, corner sums in stages 2 and 3, plane compares in stage 4, outcode
// reduction in stage 5; empty stages are filled while the result side stalls
// reset clears the valid bits and loads the identity clip matrix
module aabb_frustum_cull_test #(
	parameter int COORD_WIDTH    = afc_pkg::COORD_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = afc_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [afc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [afc_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              box_valid,
	output logic                              box_stall,
	input  logic signed [COORD_WIDTH-1:0]     min_x,
	input  logic signed [COORD_WIDTH-1:0]     min_y,
	input  logic signed [COORD_WIDTH-1:0]     min_z,
	input  logic signed [COORD_WIDTH-1:0]     max_x,
	input  logic signed [COORD_WIDTH-1:0]     max_y,
	input  logic signed [COORD_WIDTH-1:0]     max_z,
	input  logic signed [COORD_WIDTH-1:0]     eye_x,
	input  logic signed [COORD_WIDTH-1:0]     eye_y,
	input  logic signed [COORD_WIDTH-1:0]     eye_z,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic [1:0]                        verdict,
	output logic [afc_pkg::OC_W-1:0]          outcode_union,
	output logic [afc_pkg::OC_W-1:0]          outcode_common
);

	localparam int CW = afc_pkg::COEF_W;
	localparam int VW = COORD_WIDTH + CW + 2;
	localparam int DW = VW + 1;
	localparam logic [afc_pkg::CFG_W-1:0] ONE_LO = afc_pkg::CFG_W'(1) << COEF_FRAC_BITS;
	localparam logic [afc_pkg::CFG_W-1:0] ONE_HI = ONE_LO << CW;
	localparam logic [afc_pkg::CFG_W-1:0] CFG_RESET [afc_pkg::NUM_CFG] = '{
		ONE_LO, '0, ONE_HI, '0, '0, ONE_LO, '0, ONE_HI
	};

	logic [afc_pkg::CFG_W-1:0] cfg_q [afc_pkg::NUM_CFG];

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	afc_pkg::adv_t adv;

	logic eye_in_s1, eye_in_s2, eye_in_s3, eye_in_s4;
	logic eye_in;
	logic signed [VW-1:0] clip_s3 [afc_pkg::NUM_ROWS][afc_pkg::NUM_CORNERS];
	logic [afc_pkg::OC_W-1:0] oc_s4 [afc_pkg::NUM_CORNERS];
	logic [afc_pkg::OC_W-1:0] oc_next [afc_pkg::NUM_CORNERS];
	logic [afc_pkg::OC_W-1:0] oc_or, oc_and;
	logic [1:0] verdict_s5;
	logic [afc_pkg::OC_W-1:0] union_s5, common_s5;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < afc_pkg::NUM_CFG; i++) begin
				cfg_q[i] <= CFG_RESET[i];
			end
		end else if (cfg_valid && cfg_ready) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// pipeline advance, bubbles collapse
	assign en_s5     = !vld_s5 || !res_stall;
	assign en_s4     = !vld_s4 || en_s5;
	assign en_s3     = !vld_s3 || en_s4;
	assign en_s2     = !vld_s2 || en_s3;
	assign en_s1     = !vld_s1 || en_s2;
	assign box_stall = !en_s1;
	assign adv       = '{s1: en_s1, s2: en_s2, s3: en_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= box_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
		end
	end

	// eye inside box, inclusive
	assign eye_in = (eye_x >= min_x) && (eye_x <= max_x)
		&& (eye_y >= min_y) && (eye_y <= max_y)
		&& (eye_z >= min_z) && (eye_z <= max_z);

	always_ff @(posedge clk) begin
		if (en_s1) eye_in_s1 <= eye_in;
		if (en_s2) eye_in_s2 <= eye_in_s1;
		if (en_s3) eye_in_s3 <= eye_in_s2;
		if (en_s4) eye_in_s4 <= eye_in_s3;
	end

	// clip x, y, z, w rows
	for (genvar r = 0; r < afc_pkg::NUM_ROWS; r++) begin : g_row
		afc_row_eval #(
			.COORD_WIDTH(COORD_WIDTH)
		) u_row (
			.clk       (clk),
			.adv       (adv),
			.coef_x    (signed'(cfg_q[2*r][CW-1:0])),
			.coef_y    (signed'(cfg_q[2*r][2*CW-1:CW])),
			.coef_z    (signed'(cfg_q[2*r+1][CW-1:0])),
			.coef_t    (signed'(cfg_q[2*r+1][2*CW-1:CW])),
			.lo_x      (min_x),
			.lo_y      (min_y),
			.lo_z      (min_z),
			.hi_x      (max_x),
			.hi_y      (max_y),
			.hi_z      (max_z),
			.corner_s3 (clip_s3[r])
		);
	end

	// per-corner outcodes against plus and minus w
	always_comb begin
		logic signed [DW-1:0] w;
		logic signed [DW-1:0] d;
		for (int c = 0; c < afc_pkg::NUM_CORNERS; c++) begin
			w = DW'(clip_s3[3][c]);
			oc_next[c] = '0;
			for (int a = 0; a < 3; a++) begin
				d = DW'(clip_s3[a][c]) - w;
				oc_next[c][2*a] = !d[DW-1] && (d != '0);
				d = DW'(clip_s3[a][c]) + w;
				oc_next[c][2*a+1] = d[DW-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int c = 0; c < afc_pkg::NUM_CORNERS; c++) begin
				oc_s4[c] <= oc_next[c];
			end
		end
	end

	// union, intersection and verdict
	always_comb begin
		oc_or  = '0;
		oc_and = '1;
		for (int c = 0; c < afc_pkg::NUM_CORNERS; c++) begin
			oc_or  = oc_or | oc_s4[c];
			oc_and = oc_and & oc_s4[c];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			if (eye_in_s4) begin
				verdict_s5 <= afc_pkg::VERDICT_PARTIAL;
				union_s5   <= '0;
				common_s5  <= '0;
			end else begin
				if (oc_and != '0) begin
					verdict_s5 <= afc_pkg::VERDICT_REJECT;
				end else if (oc_or == '0) begin
					verdict_s5 <= afc_pkg::VERDICT_INSIDE;
				end else begin
					verdict_s5 <= afc_pkg::VERDICT_PARTIAL;
				end
				union_s5  <= oc_or;
				common_s5 <= oc_and;
			end
		end
	end

	assign res_valid      = vld_s5;
	assign verdict        = verdict_s5;
	assign outcode_union  = union_s5;
	assign outcode_common = common_s5;

endmodule

/* verif/tb_aabb_frustum_cull_test.sv */
`timescale 1ns / 1ps
// self-checking bench for aabb_frustum_cull_test: box words against several clip matrices,
// each result word compared with an in-bench cull predictor
// depends on afc_pkg and the aabb_frustum_cull_test rtl
module tb_aabb_frustum_cull_test;

	localparam int CW = afc_pkg::COORD_WIDTH_DEF;

	localparam int CLIP_ROW0_C01 = 0;
	localparam int CLIP_ROW0_C23 = 1;
	localparam int CLIP_ROW1_C01 = 2;
	localparam int CLIP_ROW1_C23 = 3;
	localparam int CLIP_ROW2_C01 = 4;
	localparam int CLIP_ROW2_C23 = 5;
	localparam int CLIP_ROW3_C01 = 6;
	localparam int CLIP_ROW3_C23 = 7;

	localparam int FAR_EYE = 1000;

	typedef struct packed {
		logic [2:0][CW-1:0] lo;
		logic [2:0][CW-1:0] hi;
		logic [2:0][CW-1:0] eye;
	} box_t;

	typedef struct packed {
		afc_pkg::verdict_t        verdict;
		logic [afc_pkg::OC_W-1:0] uni;
		logic [afc_pkg::OC_W-1:0] common;
	} cull_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [afc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [afc_pkg::CFG_W-1:0]     cfg_data = '0;
	logic                          box_valid = 1'b0;
	logic                          box_stall;
	logic signed [CW-1:0]          min_x = '0;
	logic signed [CW-1:0]          min_y = '0;
	logic signed [CW-1:0]          min_z = '0;
	logic signed [CW-1:0]          max_x = '0;
	logic signed [CW-1:0]          max_y = '0;
	logic signed [CW-1:0]          max_z = '0;
	logic signed [CW-1:0]          eye_x = '0;
	logic signed [CW-1:0]          eye_y = '0;
	logic signed [CW-1:0]          eye_z = '0;
	logic                          res_valid;
	logic                          res_stall = 1'b0;
	logic [1:0]                    verdict;
	logic [afc_pkg::OC_W-1:0]      outcode_union;
	logic [afc_pkg::OC_W-1:0]      outcode_common;

	logic [afc_pkg::CFG_W-1:0] clip_regs [afc_pkg::NUM_CFG] = '{64'h1_0000, 64'h0,
		64'h1_0000_0000_0000, 64'h0, 64'h0, 64'h1_0000, 64'h0, 64'h1_0000_0000_0000};
	cull_t pending_culls [$];
	int    error_count = 0;
	int    gap_pct = 0;
	int    hold_pct = 0;
	int    gap_set [4] = '{0, 61, 0, 19};
	int    hold_set [4] = '{0, 0, 61, 19};

	always #10 clk = ~clk;

	aabb_frustum_cull_test dut (.*);

	function automatic cull_t cull_box(box_t b);
		cull_t                    r;
		longint                   pt [3];
		longint                   clip [4];
		logic signed [31:0]       cf;
		logic [afc_pkg::OC_W-1:0] code;
		bit                       eye_in;
		eye_in = 1'b1;
		for (int a = 0; a < 3; a++)
			if (signed'(b.eye[a]) < signed'(b.lo[a]) || signed'(b.eye[a]) > signed'(b.hi[a]))
				eye_in = 1'b0;
		r.uni = '0;
		r.common = '0;
		if (eye_in) begin
			r.verdict = afc_pkg::VERDICT_PARTIAL;
			return r;
		end
		r.common = '1;
		// corner k takes the maximum on axis a when bit a of k is set
		for (int k = 0; k < afc_pkg::NUM_CORNERS; k++) begin
			for (int a = 0; a < 3; a++)
				pt[a] = k[a] ? longint'(signed'(b.hi[a])) : longint'(signed'(b.lo[a]));
			for (int row = 0; row < afc_pkg::NUM_ROWS; row++) begin
				cf = clip_regs[2*row + 1][63:32];
				clip[row] = longint'(cf);
				for (int a = 0; a < 3; a++) begin
					cf = clip_regs[2*row + a/2][32*(a%2) +: 32];
					clip[row] += longint'(cf) * pt[a];
				end
			end
			code = '0;
			code[afc_pkg::OC_RIGHT]  = clip[0] > clip[3];
			code[afc_pkg::OC_LEFT]   = clip[0] + clip[3] < 0;
			code[afc_pkg::OC_TOP]    = clip[1] > clip[3];
			code[afc_pkg::OC_BOTTOM] = clip[1] + clip[3] < 0;
			code[afc_pkg::OC_FAR]    = clip[2] > clip[3];
			code[afc_pkg::OC_NEAR]   = clip[2] + clip[3] < 0;
			r.uni |= code;
			r.common &= code;
		end
		if (r.common != '0)
			r.verdict = afc_pkg::VERDICT_REJECT;
		else if (r.uni == '0)
			r.verdict = afc_pkg::VERDICT_INSIDE;
		else
			r.verdict = afc_pkg::VERDICT_PARTIAL;
		return r;
	endfunction

	function automatic box_t boxof(input int lx, ly, lz, hx, hy, hz, ex, ey, ez);
		box_t b;
		b.lo  = {16'(lz), 16'(ly), 16'(lx)};
		b.hi  = {16'(hz), 16'(hy), 16'(hx)};
		b.eye = {16'(ez), 16'(ey), 16'(ex)};
		return b;
	endfunction

	function automatic box_t random_box();
		box_t    b;
		int      span, pick, t, u, k;
		logic [CW-1:0] tmp;
		pick = $urandom_range(99);
		case ($urandom_range(3))
			0: span = 4;
			1: span = 64;
			2: span = 2000;
			default: span = 32767;
		endcase
		if (pick < 10) begin
			for (int a = 0; a < 3; a++) begin
				b.lo[a]  = 16'($urandom());
				b.hi[a]  = 16'($urandom());
				b.eye[a] = 16'($urandom());
			end
			return b;
		end
		for (int a = 0; a < 3; a++) begin
			t = int'($urandom_range(2*span)) - span;
			u = int'($urandom_range(2*span)) - span;
			if (t > u) begin
				k = t;
				t = u;
				u = k;
			end
			b.lo[a] = 16'(t);
			b.hi[a] = 16'(u);
			if ($urandom_range(3) == 0)
				b.eye[a] = 16'(t + int'($urandom_range(u - t)));
			else
				b.eye[a] = 16'(int'($urandom_range(2*span)) - span);
		end
		// inverted box on one axis
		if (pick < 20) begin
			k = $urandom_range(2);
			tmp = b.lo[k];
			b.lo[k] = b.hi[k];
			b.hi[k] = tmp;
		end
		return b;
	endfunction

	// scaled frustum with optional shear and perspective term
	function automatic logic [7:0][63:0] view_matrix();
		logic [3:0][3:0][31:0] c;
		logic [7:0][63:0]      m;
		c = '0;
		for (int a = 0; a < 3; a++) begin
			c[a][a] = 32'($urandom_range(4 << 16, 1));
			if ($urandom_range(1))
				c[a][a] = -c[a][a];
			c[a][3] = 32'((int'($urandom_range(2000)) - 1000) << 16);
			if ($urandom_range(3) == 0)
				c[a][(a+1)%3] = 32'(int'($urandom_range(1 << 17)) - (1 << 16));
		end
		if ($urandom_range(1))
			c[3][2] = 32'(int'($urandom_range(1 << 17)) - (1 << 16));
		c[3][3] = 32'($urandom_range(3000, 1) << 16);
		for (int row = 0; row < afc_pkg::NUM_ROWS; row++) begin
			m[2*row]     = {c[row][1], c[row][0]};
			m[2*row + 1] = {c[row][3], c[row][2]};
		end
		return m;
	endfunction

	task automatic send_box(input box_t b);
		while ($urandom_range(99) < gap_pct) begin
			box_valid <= 1'b0;
			@(negedge clk);
		end
		box_valid <= 1'b1;
		min_x <= b.lo[0];
		min_y <= b.lo[1];
		min_z <= b.lo[2];
		max_x <= b.hi[0];
		max_y <= b.hi[1];
		max_z <= b.hi[2];
		eye_x <= b.eye[0];
		eye_y <= b.eye[1];
		eye_z <= b.eye[2];
		@(posedge clk);
		while (box_stall)
			@(posedge clk);
		pending_culls.push_back(cull_box(b));
		@(negedge clk);
	endtask

	task automatic wait_idle();
		box_valid <= 1'b0;
		while (pending_culls.size() != 0)
			@(posedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input int idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx[afc_pkg::CFG_IDX_W-1:0];
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		clip_regs[idx] = val;
		@(negedge clk);
	endtask

	task automatic load_matrix(input logic [7:0][63:0] m);
		for (int i = CLIP_ROW0_C01; i <= CLIP_ROW3_C23; i++)
			write_reg(i, m[i]);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// reset matrix is the identity with w = 1, so the frustum is the cube |v| <= 1
	task automatic test_identity_reset();
		send_box(boxof(0, 0, 0, 1, 1, 1, FAR_EYE, FAR_EYE, FAR_EYE));
		send_box(boxof(-1, -1, -1, 1, 1, 1, FAR_EYE, FAR_EYE, FAR_EYE));
		send_box(boxof(-5, -5, -5, 5, 5, 5, 0, 0, 0));
		send_box(boxof(-5, -5, -5, 5, 5, 5, 5, -5, 0));
		send_box(boxof(-5, -5, -5, 5, 5, 5, 6, 0, 0));
		send_box(boxof(2, 0, 0, 3, 1, 1, FAR_EYE, FAR_EYE, FAR_EYE));
		send_box(boxof(-3, 0, 0, -2, 1, 1, FAR_EYE, FAR_EYE, FAR_EYE));
		send_box(boxof(0, 2, 0, 1, 3, 1, FAR_EYE, FAR_EYE, FAR_EYE));
		send_box(boxof(0, -3, 0, 1, -2, 1, FAR_EYE, FAR_EYE, FAR_EYE));
		send_box(boxof(0, 0, 2, 1, 1, 3, FAR_EYE, FAR_EYE, FAR_EYE));
		send_box(boxof(0, 0, -3, 1, 1, -2, FAR_EYE, FAR_EYE, FAR_EYE));
		send_box(boxof(-32768, -32768, -32768, 32767, 32767, 32767, 32767, -32768, 0));
		send_box(boxof(-32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767, 32767));
		send_box(boxof(32767, 32767, 32767, 32767, 32767, 32767, -32768, -32768, -32768));
		send_box(boxof(3, 0, 0, -3, 1, 1, 0, 0, 0));
		send_box(boxof(1, 1, 1, -1, -1, -1, 0, 0, 0));
		send_box(boxof(1, -1, 1, 1, -1, 1, 1, -1, 1));
	endtask

	task automatic test_register_extremes();
		wait_idle();
		// zero matrix collapses every clip coordinate to the origin
		for (int i = CLIP_ROW0_C01; i <= CLIP_ROW3_C23; i++)
			write_reg(i, '0);
		cfg_valid <= 1'b0;
		@(negedge clk);
		send_box(boxof(-32768, -32768, -32768, 32767, 32767, -32768, 0, 0, 0));
		send_box(boxof(1, 2, 3, 4, 5, 6, 0, 0, 0));
		wait_idle();
		load_matrix({8{64'h7fff_ffff_7fff_ffff}});
		send_box(boxof(-32768, -32768, -32768, 32767, 32767, 32767, 32767, 32767, -32768));
		send_box(boxof(32767, 32767, -32768, 32767, 32767, -32768, 0, 0, 0));
		wait_idle();
		load_matrix({8{64'h8000_0000_8000_0000}});
		send_box(boxof(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0, 0));
		send_box(boxof(-32768, 0, -32768, 32767, 32767, 32767, -32768, -1, 0));
		wait_idle();
		load_matrix({8{64'hffff_ffff_ffff_ffff}});
		send_box(boxof(-7, 3, -32768, 9, 32767, 5, 100, 0, 0));
		send_box(boxof(32767, -32768, 32767, 32767, -32768, 32767, 0, 0, 0));
	endtask

	task automatic test_random_phase(input int gap, input int hold, input bit raw,
		input int count);
		logic [7:0][63:0] m;
		wait_idle();
		gap_pct = gap;
		hold_pct = hold;
		if (raw) begin
			for (int i = CLIP_ROW0_C01; i <= CLIP_ROW3_C23; i++)
				m[i] = {$urandom(), $urandom()};
		end else begin
			m = view_matrix();
		end
		load_matrix(m);
		repeat (count) send_box(random_box());
	endtask

	always @(negedge clk)
		res_stall <= arst_n && ($urandom_range(99) < hold_pct);

	always @(posedge clk) begin
		cull_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_culls.size() == 0) begin
				$error("result word with no box outstanding");
				error_count++;
			end else begin
				want = pending_culls.pop_front();
				if (verdict !== want.verdict) begin
					$error("verdict: expected %0d, got %0d", want.verdict, verdict);
					error_count++;
				end
				if (outcode_union !== want.uni) begin
					$error("outcode_union: expected %b, got %b", want.uni, outcode_union);
					error_count++;
				end
				if (outcode_common !== want.common) begin
					$error("outcode_common: expected %b, got %b", want.common,
						outcode_common);
					error_count++;
				end
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_identity_reset();
		test_register_extremes();
		for (int p = 0; p < 8; p++)
			test_random_phase(gap_set[p%4], hold_set[p%4], p >= 6, 175);
		wait_idle();
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

/* filelist.f */
sv/afc_pkg.sv
sv/afc_row_eval.sv
sv/aabb_frustum_cull_test.sv
verif/tb_aabb_frustum_cull_test.sv
